FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the saturation adjust block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/psa_pkg.sv
// Package of the pixel saturation adjust block: widths, weights and codes.
// Depends on nothing; used by every module of the block.
`default_nettype none

package psa_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int PIXEL_W          = 24;

  // Brightness P carries this many fraction bits.
  localparam int FRAC_BITS = 8;

  // Gain is in units of 1/GAIN_UNIT, and GAIN_UNIT is 2^GAIN_SHIFT - 1.
  localparam int GAIN_W     = 10;
  localparam int GAIN_SHIFT = 8;
  localparam int GAIN_UNIT  = (1 << GAIN_SHIFT) - 1;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(GAIN_UNIT);
  localparam logic [GAIN_W-1:0] GAIN_IDENTITY = GAIN_W'(GAIN_UNIT);

  // Luma weights in Q0.16; they sum to exactly 1.0.
  localparam int WEIGHT_W = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd19595;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd38470;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd7471;

  // Register port.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_SATURATION_GAIN = 2'd0;

endpackage

`default_nettype wire

FILE: hw/rtl/psa_bright_sum.sv
// Weighted sum of squared channels, the radicand of the brightness.
// Depends on psa_pkg; three register stages: squares, products, sum.
`default_nettype none

module psa_bright_sum #(
  parameter int CHANNEL_BITS = psa_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic [3*CHANNEL_BITS-1:0]                 chan_i,
  output logic [2*(CHANNEL_BITS+psa_pkg::FRAC_BITS)-1:0] sum_o,
  output logic [3*CHANNEL_BITS-1:0]                 chan_o
);
  import psa_pkg::*;

  localparam int SQ_W  = 2 * CHANNEL_BITS;
  localparam int SUM_W = 2 * (CHANNEL_BITS + FRAC_BITS);

  localparam logic [WEIGHT_W-1:0] WEIGHTS [3] = '{WEIGHT_R, WEIGHT_G, WEIGHT_B};

  logic [SQ_W-1:0]  sq_q   [3];
  logic [SUM_W-1:0] prod_q [3];
  logic [SUM_W-1:0] sum_q;
  logic [3*CHANNEL_BITS-1:0] chan1_q, chan2_q, chan3_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k]   <= SQ_W'(chan_i[(2-k)*CHANNEL_BITS +: CHANNEL_BITS])
                 * SQ_W'(chan_i[(2-k)*CHANNEL_BITS +: CHANNEL_BITS]);
      prod_q[k] <= SUM_W'(WEIGHTS[k]) * SUM_W'(sq_q[k]);
    end
    sum_q   <= prod_q[0] + prod_q[1] + prod_q[2];
    chan1_q <= chan_i;
    chan2_q <= chan1_q;
    chan3_q <= chan2_q;
  end

  assign sum_o  = sum_q;
  assign chan_o = chan3_q;

endmodule

`default_nettype wire

FILE: hw/rtl/psa_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
// Depends on psa_pkg for its parameter defaults; instantiated by the top level.
`default_nettype none

module psa_sqrt_cell #(
  parameter int ROOT_W = psa_pkg::CHANNEL_BITS_DEF + psa_pkg::FRAC_BITS,
  parameter int SIDE_W = 3 * psa_pkg::CHANNEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [2*ROOT_W-1:0]   rad_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic [ROOT_W+1:0]   rem_sh, trial, rem_d, rem_q;
  logic [ROOT_W-1:0]   root_d, root_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [SIDE_W-1:0]   side_q;

  // The incoming remainder never exceeds twice the partial root, so its
  // low ROOT_W bits hold it entirely before the next radicand pair enters.
  always_comb begin
    rem_sh = {rem_i[ROOT_W-1:0], rad_i[2*ROOT_W-1 -: 2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= {rad_i[2*ROOT_W-3:0], 2'b00};
    side_q <= side_i;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

FILE: hw/rtl/psa_chan_adjust.sv
// Per-channel adjust: P + (c - P) * gain / 255, clamped to the channel range.
// Depends on psa_pkg; four register stages, the last one drives the result.
`default_nettype none

module psa_chan_adjust #(
  parameter int CHANNEL_BITS = psa_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic [CHANNEL_BITS-1:0]                     chan_i,
  input  logic [CHANNEL_BITS+psa_pkg::FRAC_BITS-1:0]  bright_i,
  input  logic [psa_pkg::GAIN_W-1:0]                  gain_i,
  output logic [CHANNEL_BITS-1:0]                     chan_o
);
  import psa_pkg::*;

  localparam int ROOT_W  = CHANNEL_BITS + FRAC_BITS;
  localparam int DIFF_W  = ROOT_W + 1;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int P255_W  = ROOT_W + GAIN_SHIFT;
  localparam int T_W     = PROD_W + 1;
  localparam int U_W     = CHANNEL_BITS + GAIN_SHIFT;
  localparam int SHIFT   = U_W + GAIN_SHIFT;
  localparam longint unsigned RECIP_VAL = (64'd1 << SHIFT) / GAIN_UNIT;
  localparam int RECIP_W = U_W + 1;
  localparam int MUL_W   = U_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam logic signed [T_W-1:0] T_OVER =
    T_W'(longint'(GAIN_UNIT) << (CHANNEL_BITS + FRAC_BITS));
  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

  // Stage 1: the two products that make up t.
  logic signed [DIFF_W-1:0]   diff;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic        [P255_W-1:0]   p255_d, p255_q;

  assign diff   = $signed({1'b0, chan_i, FRAC_BITS'(0)}) - $signed({1'b0, bright_i});
  assign gain_s = $signed({1'b0, gain_i});
  assign prod_d = diff * gain_s;
  assign p255_d = {bright_i, GAIN_SHIFT'(0)} - P255_W'(bright_i);

  // Stage 2: t, its sign and whether it overflows the channel.
  logic signed [T_W-1:0] t_sum;
  logic                  neg2_q, over2_q;
  logic [U_W-1:0]        u2_q;

  assign t_sum = T_W'($signed({1'b0, p255_q})) + T_W'(prod_q);

  // Stage 3: quotient estimate by reciprocal multiply.
  logic                  neg3_q, over3_q;
  logic [U_W-1:0]        u3_q;
  logic [MUL_W-1:0]      mul_q;

  // Stage 4: the estimate is low by at most one; one compare fixes it.
  logic [CHANNEL_BITS-1:0] q_est, q_fix, chan_d, chan_q;
  logic [U_W-1:0]          rem;

  always_comb begin
    q_est = mul_q[SHIFT +: CHANNEL_BITS];
    rem   = u3_q - ({q_est, GAIN_SHIFT'(0)} - U_W'(q_est));
    q_fix = (rem >= U_W'(GAIN_UNIT)) ? q_est + 1'b1 : q_est;
    if (neg3_q) begin
      chan_d = '0;
    end else if (over3_q) begin
      chan_d = CHAN_MAX;
    end else begin
      chan_d = q_fix;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p255_q  <= p255_d;
    neg2_q  <= t_sum[T_W-1];
    over2_q <= (t_sum >= T_OVER);
    u2_q    <= t_sum[FRAC_BITS +: U_W];
    neg3_q  <= neg2_q;
    over3_q <= over2_q;
    u3_q    <= u2_q;
    mul_q   <= MUL_W'(u2_q) * MUL_W'(RECIP);
    chan_q  <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_saturation_adjust.sv
// Top level of the pixel saturation adjust block.
// Depends on psa_pkg, psa_bright_sum, psa_sqrt_cell, psa_chan_adjust, assert_macros.svh.
//
// Usage: a pixel item is offered on pixel_in_i with start high and is taken
// at that clock edge, since busy stays low; the block takes one item in every
// cycle. Each item gives one adjusted pixel on pixel_out_o, marked by
// result_valid_o for a single cycle. The receiver cannot stall the block,
// so no item ever waits inside it and results leave in the order items came.
// The core is a square root chain of CHANNEL_BITS + 8 cells, one root bit
// per cell, fed by three stages that form the weighted sum of squares and
// followed by four stages per channel that scale, divide by 255 and clamp.
// All stages advance every cycle, so throughput is one item per clock.
// The gain register is written over the APB-style port at address 0
// and may be changed only while no item is in flight. Reset clears the valid
// line, so no result appears until an item is taken, and sets the gain to
// 255, which passes pixels through unchanged.
`default_nettype none
`include "assert_macros.svh"

module pixel_saturation_adjust #(
  parameter int CHANNEL_BITS = psa_pkg::CHANNEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [psa_pkg::PIXEL_W-1:0]      pixel_in_i,
  output logic                             result_valid_o,
  output logic [psa_pkg::PIXEL_W-1:0]      pixel_out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [psa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [psa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [psa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import psa_pkg::*;

  localparam int CHAN3_W = 3 * CHANNEL_BITS;
  localparam int ROOT_W  = CHANNEL_BITS + FRAC_BITS;
  localparam int LATENCY = 3 + ROOT_W + 4;
  localparam logic [PIXEL_W-1:0] IN_MASK =
    (CHAN3_W >= PIXEL_W) ? '1 : PIXEL_W'((64'd1 << CHAN3_W) - 1);

  // Gain register. Writes land on the access phase of the port.
  logic [GAIN_W-1:0] gain_d, gain_q;

  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(gain_q);

  always_comb begin
    gain_d = gain_q;
    if (psel && penable && pwrite && pready && (paddr == ADDR_SATURATION_GAIN)) begin
      gain_d = pwdata[GAIN_W-1:0];
    end
  end

  // Valid line that runs alongside the datapath.
  logic [LATENCY-1:0] vld_d, vld_q;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[LATENCY-2:0], start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      vld_q  <= '0;
    end else begin
      gain_q <= gain_d;
      vld_q  <= vld_d;
    end
  end

  assign result_valid_o = vld_q[LATENCY-1];

  // Channels of the incoming pixel; input bits above the channels are ignored,
  // and missing high bits of wide channels read as zero.
  logic [CHAN3_W-1:0] px_used;

  if (CHAN3_W >= PIXEL_W) begin : g_in_wide
    assign px_used = CHAN3_W'(pixel_in_i);
  end else begin : g_in_narrow
    assign px_used = pixel_in_i[CHAN3_W-1:0];
  end

  // Weighted sum of squares.
  logic [2*ROOT_W-1:0] sum;
  logic [CHAN3_W-1:0]  chan_sum;

  psa_bright_sum #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_sum (
    .clk_i  (clk_i),
    .chan_i (px_used),
    .sum_o  (sum),
    .chan_o (chan_sum)
  );

  // Square root chain. The channels ride along in each cell so they reach
  // the adjust stages together with the brightness.
  logic [ROOT_W+1:0]   rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_w [ROOT_W+1];
  logic [2*ROOT_W-1:0] rad_w  [ROOT_W+1];
  logic [CHAN3_W-1:0]  side_w [ROOT_W+1];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = sum;
  assign side_w[0] = chan_sum;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    psa_sqrt_cell #(
      .ROOT_W(ROOT_W),
      .SIDE_W(CHAN3_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rad_i  (rad_w[i]),
      .side_i (side_w[i]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1]),
      .rad_o  (rad_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  // Per-channel scaling, red first.
  logic [CHANNEL_BITS-1:0] ch_res [3];

  for (genvar k = 0; k < 3; k++) begin : g_adj
    psa_chan_adjust #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_adj (
      .clk_i    (clk_i),
      .chan_i   (side_w[ROOT_W][(2-k)*CHANNEL_BITS +: CHANNEL_BITS]),
      .bright_i (root_w[ROOT_W]),
      .gain_i   (gain_q),
      .chan_o   (ch_res[k])
    );
  end

  // Packing; wide channels are cut to the output field.
  logic [CHAN3_W-1:0] px_res;

  assign px_res = {ch_res[0], ch_res[1], ch_res[2]};

  if (CHAN3_W >= PIXEL_W) begin : g_out_wide
    assign pixel_out_o = px_res[PIXEL_W-1:0];
  end else begin : g_out_narrow
    assign pixel_out_o = PIXEL_W'(px_res);
  end

  // A grey pixel has brightness equal to its channels and so comes back as it
  // went in, whatever the gain.
  logic grey_in;

  assign grey_in = (px_used[2*CHANNEL_BITS +: CHANNEL_BITS]
                    == px_used[CHANNEL_BITS +: CHANNEL_BITS])
                && (px_used[CHANNEL_BITS +: CHANNEL_BITS]
                    == px_used[0 +: CHANNEL_BITS]);

  `PSA_ASSERT_IMP(a_result_has_item, clk_i, rst_ni, result_valid_o, $past(start, LATENCY), "result without an item taken at the pipeline latency")
  `PSA_ASSERT_IMP(a_grey_kept, clk_i, rst_ni, result_valid_o && $past(start && grey_in, LATENCY), pixel_out_o == $past(pixel_in_i & IN_MASK, LATENCY), "grey pixel was altered")
  `PSA_ASSERT_IMP(a_zero_gain_grey, clk_i, rst_ni, result_valid_o && (gain_q == '0), (ch_res[0] == ch_res[1]) && (ch_res[1] == ch_res[2]), "zero gain did not give a grey pixel")
  `PSA_ASSERT_NXT(a_identity_gain, clk_i, rst_ni, vld_q[LATENCY-2] && (gain_q == GAIN_IDENTITY), pixel_out_o == $past(pixel_in_i & IN_MASK, LATENCY), "identity gain changed the pixel")

endmodule

`default_nettype wire

FILE: tb/sv/psa_pixel_checker.sv
// Checker of the pixel saturation adjust block: predicts every adjusted pixel.
// It also tracks the gain register and checks register reads.
// Depends on psa_pkg; instantiated by tb_top beside the block.
module psa_pixel_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [psa_pkg::PIXEL_W-1:0]      pixel_in_i,
  input  logic                             result_valid_i,
  input  logic [psa_pkg::PIXEL_W-1:0]      pixel_out_i,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [psa_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [psa_pkg::APB_DATA_W-1:0]   pwdata_i,
  input  logic [psa_pkg::APB_DATA_W-1:0]   prdata_i,
  input  logic                             pready_i,
  input  logic                             end_of_run_i,
  output int                               pending_o,
  output int                               fail_count_o
);
  import psa_pkg::*;

  localparam int CHAN_W   = CHANNEL_BITS_DEF;
  localparam int CHAN_TOP = (1 << CHAN_W) - 1;

  logic [PIXEL_W-1:0] expected_pixels_q[$];
  logic [PIXEL_W-1:0] pixels_taken_q[$];
  logic [GAIN_W-1:0]  gain_now;
  int                 fail_count = 0;
  bit                 end_seen = 1'b0;

  assign fail_count_o = fail_count;

  task automatic flag_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Floor of the square root, one root bit per pass.
  function automatic logic [2*FRAC_BITS-1:0] brightness_q8(input longint unsigned sum_sq);
    longint unsigned rem, root, probe;
    rem   = sum_sq;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root[2*FRAC_BITS-1:0];
  endfunction

  // P + (c - P) * gain / 255, all scaled by 255 * 256, floored and clamped.
  function automatic logic [CHAN_W-1:0] adjusted_channel(input logic [CHAN_W-1:0] chan,
                                                         input logic [2*FRAC_BITS-1:0] bright,
                                                         input logic [GAIN_W-1:0] gain);
    longint pv, diff, scaled, quot;
    pv     = longint'(bright);
    diff   = (longint'(chan) << FRAC_BITS) - pv;
    scaled = pv * GAIN_UNIT + diff * longint'(gain);
    if (scaled < 0) return '0;
    quot = scaled / (GAIN_UNIT * (1 << FRAC_BITS));
    if (quot > CHAN_TOP) quot = CHAN_TOP;
    return quot[CHAN_W-1:0];
  endfunction

  function automatic logic [PIXEL_W-1:0] adjusted_pixel(input logic [PIXEL_W-1:0] pix,
                                                        input logic [GAIN_W-1:0] gain);
    logic [CHAN_W-1:0]       red, green, blue;
    longint unsigned         sum_sq;
    logic [2*FRAC_BITS-1:0]  bright;
    red    = pix[3*CHAN_W-1 -: CHAN_W];
    green  = pix[2*CHAN_W-1 -: CHAN_W];
    blue   = pix[CHAN_W-1:0];
    sum_sq = 64'(WEIGHT_R) * red * red + 64'(WEIGHT_G) * green * green
           + 64'(WEIGHT_B) * blue * blue;
    bright = brightness_q8(sum_sq);
    return PIXEL_W'({adjusted_channel(red, bright, gain),
                     adjusted_channel(green, bright, gain),
                     adjusted_channel(blue, bright, gain)});
  endfunction

  always @(posedge clk_i) begin
    logic [PIXEL_W-1:0] want, seen_in;
    if (!rst_ni) begin
      gain_now = GAIN_RESET;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          // Only address 0 holds a register; other addresses drop the write.
          if (paddr_i == ADDR_SATURATION_GAIN) gain_now = pwdata_i[GAIN_W-1:0];
        end else if (paddr_i == ADDR_SATURATION_GAIN &&
                     prdata_i !== APB_DATA_W'(gain_now)) begin
          flag_mismatch($sformatf("gain read %0h, want %0h", prdata_i, gain_now));
        end
      end
      if (start_i && !busy_i) begin
        expected_pixels_q.push_back(adjusted_pixel(pixel_in_i, gain_now));
        pixels_taken_q.push_back(pixel_in_i);
      end
      if (result_valid_i !== 1'b0) begin
        if (expected_pixels_q.size() == 0) begin
          flag_mismatch($sformatf("pixel %06h out with none pending", pixel_out_i));
        end else begin
          want    = expected_pixels_q.pop_front();
          seen_in = pixels_taken_q.pop_front();
          if (result_valid_i !== 1'b1 || pixel_out_i !== want)
            flag_mismatch($sformatf("pixel_out for %06h at gain %0d: got %06h, want %06h",
                                    seen_in, gain_now, pixel_out_i, want));
        end
      end
      if (end_of_run_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_pixels_q.size() != 0)
          flag_mismatch($sformatf("%0d pixels never came out", expected_pixels_q.size()));
      end
    end
    pending_o <= expected_pixels_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the pixel saturation adjust testbench: clock, reset, stimulus, verdict.
// Depends on psa_pkg, pixel_saturation_adjust and psa_pixel_checker.
module tb_top;
  import psa_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int PIPE_LATENCY  = CHANNEL_BITS_DEF + 15;
  localparam int MAX_GAP       = 6;
  localparam int PHASE_ITEMS   = 128;
  // Cycles without any accepted item, result or register access before we
  // give up.
  localparam int STALL_LIMIT   = 4000;
  localparam int GAIN_MAX      = (1 << GAIN_W) - 1;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  logic [PIXEL_W-1:0]    pixel_in   = '0;
  logic                  result_valid;
  logic [PIXEL_W-1:0]    pixel_out;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  end_of_run = 1'b0;
  int                    pending;
  int                    fail_count;
  int                    stall_cycles = 0;
  // When low, the feeder never leaves gaps between items.
  bit                    gaps_on = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  pixel_saturation_adjust dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_in_i     (pixel_in),
    .result_valid_o (result_valid),
    .pixel_out_o    (pixel_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  psa_pixel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .pixel_in_i     (pixel_in),
    .result_valid_i (result_valid),
    .pixel_out_i    (pixel_out),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .end_of_run_i   (end_of_run),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // The watchdog restarts whenever anything moves on any port; a hang in
  // the block or in the handshakes trips it.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Both register tasks start on a clock edge and return on a later edge
  // with psel already dropped, so calls can follow one another directly.
  task automatic reg_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the gain with random junk in the unused upper data bits.
  task automatic set_gain(input int gain);
    logic [APB_DATA_W-1:0] word;
    word              = $urandom();
    word[GAIN_W-1:0]  = GAIN_W'(gain);
    reg_access(1'b1, ADDR_SATURATION_GAIN, word);
  endtask

  // Offers one pixel and returns at the edge that takes it. With gaps on,
  // start may drop for a random gap first and the pixel bus carries noise.
  task automatic feed_pixel(input logic [PIXEL_W-1:0] pix);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      start    <= 1'b0;
      pixel_in <= PIXEL_W'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    pixel_in <= pix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stops feeding and waits until every pixel in flight has come out, so
  // that the gain may be changed safely.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  // Mostly fully random colors, mixed with greys, near-greys and pixels
  // built from channel extremes, which hit the clamps at high gains.
  function automatic logic [PIXEL_W-1:0] draw_pixel();
    logic [7:0] base, red, green, blue;
    int         spread;
    base = 8'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        return {base, base, base};
      end
      1: begin
        spread = $urandom_range(1, 6);
        red    = 8'(base + $urandom_range(0, 2 * spread) - spread);
        green  = 8'(base + $urandom_range(0, 2 * spread) - spread);
        blue   = 8'(base + $urandom_range(0, 2 * spread) - spread);
        return {red, green, blue};
      end
      2: begin
        red   = ($urandom_range(0, 2) == 0) ? base : {8{$urandom_range(0, 1) == 1}};
        green = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : {8{$urandom_range(0, 1) == 1}};
        blue  = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : {8{$urandom_range(0, 1) == 1}};
        return {red, green, blue};
      end
      default: begin
        return PIXEL_W'($urandom());
      end
    endcase
  endfunction

  // Black, white, a mid grey, the three primaries, a near-black grey and
  // one mixed color. At gain 255 each must come back unchanged, at 0 each
  // turns grey, and at 1023 the primaries drive channels into both clamps.
  logic [PIXEL_W-1:0] corner_pixels [8] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
    24'h00FF00, 24'h0000FF, 24'h010101, 24'hA5325C
  };

  int phase_gains [10] = '{1, 254, 256, 511, 512, 1022, -1, -1, 0, GAIN_MAX};

  initial begin
    int gain;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The gain must read back as its reset value first.
    reg_access(1'b0, ADDR_SATURATION_GAIN, '0);
    foreach (corner_pixels[i]) feed_pixel(corner_pixels[i]);
    drain_pipeline();

    // All ones on the data bus leaves the largest gain. Writes to the
    // addresses that hold no register must not disturb it.
    reg_access(1'b1, ADDR_SATURATION_GAIN, {APB_DATA_W{1'b1}});
    for (int a = 1; a < (1 << APB_ADDR_W); a++) reg_access(1'b1, APB_ADDR_W'(a), '0);
    reg_access(1'b0, ADDR_SATURATION_GAIN, '0);
    gaps_on = 1'b1;
    foreach (corner_pixels[i]) feed_pixel(corner_pixels[i]);
    drain_pipeline();

    set_gain(0);
    foreach (corner_pixels[i]) feed_pixel(corner_pixels[i]);
    drain_pipeline();

    // Random part: one gain per phase, idling switched on or off per phase.
    foreach (phase_gains[p]) begin
      gain = (phase_gains[p] < 0) ? $urandom_range(0, GAIN_MAX) : phase_gains[p];
      set_gain(gain);
      if ($urandom_range(0, 1) == 1) reg_access(1'b0, ADDR_SATURATION_GAIN, '0);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) feed_pixel(draw_pixel());
      drain_pipeline();
    end

    end_of_run <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
